@@ hdl/stt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, constants and character helpers of the text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int POS_W       = 16;
  localparam int LEN_W       = 16;
  localparam int NUM_WORDS   = 6;
  localparam int WORD_SLOTS  = 8;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [NUM_WORDS-1:0] cand_t;
  typedef logic [7:0]           char_t;

  typedef enum logic [3:0] {
    KIND_SPACE   = 4'd0,
    KIND_TYPE    = 4'd1,
    KIND_KEYWORD = 4'd2,
    KIND_IDENT   = 4'd3,
    KIND_INT     = 4'd4,
    KIND_DOUBLE  = 4'd5,
    KIND_STRING  = 4'd6,
    KIND_OPER    = 4'd7,
    KIND_CHAR    = 4'd8,
    KIND_END     = 4'd9,
    KIND_UNTERM  = 4'd10
  } kind_t;

  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_WORD = 5'b00010,
    MODE_NUM  = 5'b00100,
    MODE_STR  = 5'b01000,
    MODE_CMT  = 5'b10000
  } mode_t;

  typedef struct packed {
    kind_t      kind;
    logic [15:0] start;
    len_t       len;
    logic [2:0] word;
  } token_t;

  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } tok_pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // characters
  localparam char_t CH_NL    = 8'h0A;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_VT    = 8'h0B;
  localparam char_t CH_FF    = 8'h0C;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_HASH  = 8'h23;
  localparam char_t CH_DOT   = 8'h2E;
  localparam char_t CH_QUOTE = 8'h27;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_STAR  = 8'h2A;
  localparam char_t CH_SLASH = 8'h2F;

  // reserved words, zero padded: int long input struct return define
  localparam char_t WORD_TEXT [NUM_WORDS][WORD_SLOTS] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "o", "n", "g", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "p", "u", "t", 8'h00, 8'h00, 8'h00},
    '{"s", "t", "r", "u", "c", "t", 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"d", "e", "f", "i", "n", "e", 8'h00, 8'h00}
  };
  localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{4'd3, 4'd4, 4'd5, 4'd6, 4'd6, 4'd6};
  localparam int NUM_TYPE_WORDS = 2;

  function automatic logic is_alpha(input char_t c);
    is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input char_t c);
    is_digit = (c >= "0" && c <= "9");
  endfunction

  function automatic logic is_blank(input char_t c);
    is_blank = (c == CH_SPACE) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_oper(input char_t c);
    is_oper = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  function automatic len_t sat_inc(input len_t v);
    sat_inc = (&v) ? v : len_t'(v + 1'b1);
  endfunction

  function automatic token_t make_tok(input kind_t k, input pos_t s, input len_t l,
                                      input logic [2:0] w);
    token_t t;
    t.kind  = k;
    t.start = 16'(s);
    t.len   = l;
    t.word  = w;
    make_tok = t;
  endfunction

endpackage

@@ hdl/stt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_in_if / stt_out_if
// Valid/ready channels for source bytes and for tokens.
// ----------------------------------------------------------------------------
interface stt_in_if;
  import stt_pkg::*;

  logic  valid;
  logic  ready;
  char_t text_byte;
  logic  end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface stt_out_if;
  import stt_pkg::*;

  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic [2:0]  reserved_word;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output reserved_word, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input token_length, input reserved_word, input last_of_run,
                  output ready);
endinterface

@@ hdl/stt_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_scan
// Front end: takes bytes, tracks scan mode and forms up to two tokens a byte.
// ----------------------------------------------------------------------------
module stt_scan (
  input  logic                clk,
  input  logic                rst_n,
  stt_in_if.sink              in_ch,
  input  stt_pkg::q_status_t  q_stat_i,
  output logic                push_o,
  output stt_pkg::tok_pair_t  pair_o
);
  import stt_pkg::*;

  typedef struct packed {
    logic   emit;
    token_t tok;
    mode_t  mode;
    logic   load;
    pos_t   tstart;
    len_t   tcount;
    logic   dot;
    cand_t  cand;
  } start_res_t;

  mode_t mode_r, mode_nxt;
  logic  dot_r, dot_nxt;
  pos_t  tstart_r, tstart_nxt;
  len_t  count_r, count_nxt;
  pos_t  pos_r, pos_nxt;
  cand_t cand_r, cand_nxt;

  logic       acc;
  char_t      b;
  start_res_t st;
  logic       use_start;
  logic       pend_v;
  token_t     pend_tok;
  logic       second_v;
  token_t     second_tok;

  function automatic cand_t narrow(input cand_t c, input len_t idx, input char_t ch);
    cand_t r;
    r = c;
    for (int k = 0; k < NUM_WORDS; k++) begin
      if (idx >= len_t'(WORD_LEN[k]) || WORD_TEXT[k][idx[2:0]] != ch) begin
        r[k] = 1'b0;
      end
    end
    narrow = r;
  endfunction

  function automatic token_t finish_word(input cand_t c, input pos_t s, input len_t n);
    token_t t;
    t = make_tok(KIND_IDENT, s, n, 3'd0);
    for (int k = NUM_WORDS - 1; k >= 0; k--) begin
      if (c[k] && len_t'(WORD_LEN[k]) == n) begin
        t = make_tok((k < NUM_TYPE_WORDS) ? KIND_TYPE : KIND_KEYWORD, s, n, 3'(k));
      end
    end
    finish_word = t;
  endfunction

  function automatic start_res_t start_token(input char_t c, input pos_t p);
    start_res_t r;
    r        = '0;
    r.mode   = MODE_IDLE;
    r.cand   = '1;
    r.tstart = p;
    r.tok    = make_tok(KIND_CHAR, p, len_t'(1), 3'd0);
    if (c == CH_NL || c == CH_TAB) begin
      r.emit = 1'b1;
      r.tok  = make_tok(KIND_SPACE, p, len_t'(1), 3'd0);
    end else if (is_blank(c)) begin
      r.emit = 1'b0;
    end else if (is_alpha(c)) begin
      r.mode   = MODE_WORD;
      r.load   = 1'b1;
      r.tcount = len_t'(1);
      r.cand   = narrow('1, '0, c);
    end else if (is_digit(c) || c == CH_DOT) begin
      r.mode   = MODE_NUM;
      r.load   = 1'b1;
      r.tcount = len_t'(1);
      r.dot    = (c == CH_DOT);
    end else if (c == CH_QUOTE) begin
      r.mode   = MODE_STR;
      r.load   = 1'b1;
      r.tstart = pos_t'(p + 1'b1);
    end else if (c == CH_HASH) begin
      r.mode = MODE_CMT;
    end else if (is_oper(c)) begin
      r.emit = 1'b1;
      r.tok  = make_tok(KIND_OPER, p, len_t'(1), 3'd0);
    end else begin
      r.emit = 1'b1;
    end
    start_token = r;
  endfunction

  assign in_ch.ready = !q_stat_i.full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign b           = in_ch.text_byte;
  assign st          = start_token(b, pos_r);

  always_comb begin
    mode_nxt   = mode_r;
    dot_nxt    = dot_r;
    tstart_nxt = tstart_r;
    count_nxt  = count_r;
    cand_nxt   = cand_r;
    pos_nxt    = pos_t'(pos_r + 1'b1);
    use_start  = 1'b0;
    pend_v     = 1'b0;
    pend_tok   = finish_word(cand_r, tstart_r, count_r);
    second_v   = 1'b0;
    second_tok = st.tok;

    if (in_ch.end_of_text) begin
      // flush, end token, back to reset state
      unique case (mode_r)
        MODE_WORD: pend_v = 1'b1;
        MODE_NUM: begin
          pend_v   = 1'b1;
          pend_tok = make_tok(dot_r ? KIND_DOUBLE : KIND_INT, tstart_r, count_r, 3'd0);
        end
        MODE_STR: begin
          pend_v   = 1'b1;
          pend_tok = make_tok(KIND_UNTERM, tstart_r, count_r, 3'd0);
        end
        default: pend_v = 1'b0;
      endcase
      second_v   = 1'b1;
      second_tok = make_tok(KIND_END, pos_r, '0, 3'd0);
      mode_nxt   = MODE_IDLE;
      dot_nxt    = 1'b0;
      tstart_nxt = '0;
      count_nxt  = '0;
      cand_nxt   = '1;
      pos_nxt    = '0;
    end else begin
      unique case (mode_r)
        MODE_WORD: begin
          if (is_alpha(b) || is_digit(b)) begin
            cand_nxt  = narrow(cand_r, count_r, b);
            count_nxt = sat_inc(count_r);
          end else begin
            pend_v    = 1'b1;
            use_start = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit(b) || b == CH_DOT) begin
            dot_nxt   = dot_r || (b == CH_DOT);
            count_nxt = sat_inc(count_r);
          end else begin
            pend_v    = 1'b1;
            pend_tok  = make_tok(dot_r ? KIND_DOUBLE : KIND_INT, tstart_r, count_r, 3'd0);
            dot_nxt   = 1'b0;
            use_start = 1'b1;
          end
        end
        MODE_STR: begin
          if (b == CH_QUOTE) begin
            pend_v   = 1'b1;
            pend_tok = make_tok(KIND_STRING, tstart_r, count_r, 3'd0);
            mode_nxt = MODE_IDLE;
          end else begin
            count_nxt = sat_inc(count_r);
          end
        end
        MODE_CMT: begin
          use_start = (b == CH_NL) || (b == CH_CR);
        end
        default: use_start = 1'b1;
      endcase
      if (use_start) begin
        mode_nxt = st.mode;
        second_v = st.emit;
        if (st.load) begin
          tstart_nxt = st.tstart;
          count_nxt  = st.tcount;
          dot_nxt    = st.dot;
          cand_nxt   = st.cand;
        end
      end
    end
  end

  always_comb begin
    pair_o.first  = pend_v ? pend_tok : second_tok;
    pair_o.second = second_tok;
    pair_o.two    = pend_v && second_v;
    push_o        = acc && (pend_v || second_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      dot_r    <= 1'b0;
      tstart_r <= '0;
      count_r  <= '0;
      pos_r    <= '0;
      cand_r   <= '1;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      dot_r    <= dot_nxt;
      tstart_r <= tstart_nxt;
      count_r  <= count_nxt;
      pos_r    <= pos_nxt;
      cand_r   <= cand_nxt;
    end
  end

  a_eot_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.end_of_text |=> pos_r == '0 && mode_r == MODE_IDLE)
    else $error("position or mode not cleared after end of text");

  a_eot_always_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.end_of_text |-> push_o)
    else $error("end of text accepted without an end token");

endmodule

@@ hdl/stt_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_fifo
// Short flop queue of token pairs between scanner and emitter.
// ----------------------------------------------------------------------------
module stt_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  stt_pkg::tok_pair_t  pair_i,
  input  logic                pop_i,
  output stt_pkg::tok_pair_t  head_o,
  output stt_pkg::q_status_t  stat_o
);
  import stt_pkg::*;

  tok_pair_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;

  assign head_o       = mem_r[rd_ptr_r];
  assign stat_o.full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat_o.empty = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (push_i && !pop_i) begin
      count_nxt = FIFO_CNT_W'(count_r + 1'b1);
    end else if (pop_i && !push_i) begin
      count_nxt = FIFO_CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= pair_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= FIFO_PTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_r <= FIFO_PTR_W'(rd_ptr_r + 1'b1);
      end
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !stat_o.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");

endmodule

@@ hdl/stt_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_emit
// Back end: unpacks queued token pairs, one output token a cycle while ready.
// ----------------------------------------------------------------------------
module stt_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  stt_pkg::tok_pair_t  head_i,
  input  stt_pkg::q_status_t  q_stat_i,
  output logic                pop_o,
  stt_out_if.source           out_ch
);
  import stt_pkg::*;

  logic   valid_r, valid_nxt;
  logic   idx_r, idx_nxt;
  token_t tok_r;
  logic   last_r;

  logic   load;
  logic   sel_last;
  token_t sel_tok;

  assign load     = !valid_r || out_ch.ready;
  assign sel_last = idx_r || !head_i.two;
  assign sel_tok  = idx_r ? head_i.second : head_i.first;
  assign pop_o    = load && !q_stat_i.empty && sel_last;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        idx_nxt = !sel_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_stat_i.empty) begin
      tok_r  <= sel_tok;
      last_r <= sel_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.token_kind    = tok_r.kind;
  assign out_ch.start_offset  = tok_r.start;
  assign out_ch.token_length  = tok_r.len;
  assign out_ch.reserved_word = tok_r.word;
  assign out_ch.last_of_run   = last_r;

  a_second_half_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r |-> !q_stat_i.empty && head_i.two)
    else $error("second token pending without a two-token head");

endmodule

@@ hdl/source_text_tokenizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_core
// Byte-serial lexical analyser for a small C-like language.
// ----------------------------------------------------------------------------
// The block takes one byte (or an end-of-text marker) per transfer and can
// accept a new one every cycle while the token queue is not full. Each byte
// gives zero, one or two tokens; the token port delivers one token per cycle
// from a registered output stage while the output is ready, so a byte that
// yields two tokens leaves as two output transfers, and sustained input rate
// is one byte per cycle as long as the text averages at most one token per
// byte. A token is written into the four-entry token queue on the transfer
// that caused it and is then loaded into the output register, from which it
// is presented. When the queue fills the input stalls; the output side may
// stall freely. The last token caused by a byte carries last_of_run, and the
// end token always does. After end of text all scan state, including the
// text position, returns to its reset values.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core (
  input  logic       clk,
  input  logic       rst_n,
  stt_in_if.sink     in_ch,
  stt_out_if.source  out_ch
);
  import stt_pkg::*;

  // scanner to queue
  logic      push;
  tok_pair_t push_pair;

  // queue to emitter
  tok_pair_t head_pair;
  q_status_t q_stat;
  logic      pop;

  // front: classifies bytes, forms token pairs
  stt_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat_i (q_stat),
    .push_o   (push),
    .pair_o   (push_pair)
  );

  // decoupling queue, lets either side stall on its own
  stt_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pair_i (push_pair),
    .pop_i  (pop),
    .head_o (head_pair),
    .stat_o (q_stat)
  );

  // back: one token per output transfer
  stt_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_i   (head_pair),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_ch   (out_ch)
  );

  // a full queue must hold off input
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_ch.ready)
    else $error("input ready while token queue full");

endmodule
